[design/wrd_pkg.sv]
// ----------------------------------------------------------------------------
// wrd_pkg: shared types and constants
// Widths and sideband record of the radial basis displacement pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package wrd_pkg;

  localparam int COORD_W = 10;          // voxel coordinate width
  localparam int REG_W   = 16;          // configuration register width
  localparam int MM_W    = COORD_W + REG_W;  // scaled axis distance
  localparam int D2_W    = 2 * REG_W;   // squared distance inside support
  localparam int ROOT_W  = D2_W;        // isqrt of d2 * 2^32
  localparam int REM_W   = 2 * ROOT_W;  // sqrt remainder
  localparam int Q_W     = REG_W + 1;   // Q0.16 value up to 1.0
  localparam int DREM_W  = ROOT_W + 1;  // divider remainder
  localparam int IDX_W   = 2;
  localparam int IN_W    = 112;
  localparam int OUT_W   = 48;

  localparam logic [Q_W-1:0] ONE_Q16 = 17'h10000;

  typedef enum logic [IDX_W-1:0] {
    REG_SPACING_X = 2'd0,
    REG_SPACING_Y = 2'd1,
    REG_SPACING_Z = 2'd2,
    REG_RADIUS    = 2'd3
  } reg_idx_t;

  // payload and flags that ride along the pipeline
  typedef struct packed {
    logic signed [REG_W-1:0] coeff_x;
    logic signed [REG_W-1:0] coeff_y;
    logic signed [REG_W-1:0] coeff_z;
    logic                    in_sup;
    logic                    rzero;
  } side_t;

endpackage

`default_nettype wire

[design/wrd_dist.sv]
// ----------------------------------------------------------------------------
// wrd_dist: squared distance and support test
// Five stages: axis differences, spacing scale, squares, sum, compare.
// ----------------------------------------------------------------------------
`default_nettype none

module wrd_dist (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire logic [wrd_pkg::COORD_W-1:0]   vx,
  input  wire logic [wrd_pkg::COORD_W-1:0]   vy,
  input  wire logic [wrd_pkg::COORD_W-1:0]   vz,
  input  wire logic [wrd_pkg::COORD_W-1:0]   cx,
  input  wire logic [wrd_pkg::COORD_W-1:0]   cy,
  input  wire logic [wrd_pkg::COORD_W-1:0]   cz,
  input  wire wrd_pkg::side_t                side_in,
  input  wire logic [wrd_pkg::REG_W-1:0]     spacing_x,
  input  wire logic [wrd_pkg::REG_W-1:0]     spacing_y,
  input  wire logic [wrd_pkg::REG_W-1:0]     spacing_z,
  input  wire logic [wrd_pkg::REG_W-1:0]     radius,
  output logic                               out_valid,
  output logic [wrd_pkg::D2_W-1:0]           d2,
  output wrd_pkg::side_t                     side_out
);
  import wrd_pkg::*;

  logic [3:0]          valid;
  side_t               side1, side2, side3, side4;
  logic [COORD_W-1:0]  ax, ay, az;
  logic [MM_W-1:0]     mx, my, mz;
  logic [D2_W-1:0]     sqx, sqy, sqz, rsq3, rsq4;
  logic                far3, far4;
  logic [D2_W+1:0]     sum4;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      valid     <= {valid[2:0], in_valid};
      out_valid <= valid[3];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // S1: absolute axis differences
      ax <= (vx >= cx) ? vx - cx : cx - vx;
      ay <= (vy >= cy) ? vy - cy : cy - vy;
      az <= (vz >= cz) ? vz - cz : cz - vz;
      side1       <= side_in;
      side1.rzero <= (radius == '0);
      // S2: millimetres
      mx    <= MM_W'(ax) * MM_W'(spacing_x);
      my    <= MM_W'(ay) * MM_W'(spacing_y);
      mz    <= MM_W'(az) * MM_W'(spacing_z);
      side2 <= side1;
      // S3: one axis beyond R is already outside; else each fits 16 bits
      far3  <= (mx > MM_W'(radius)) || (my > MM_W'(radius)) || (mz > MM_W'(radius));
      sqx   <= mx[REG_W-1:0] * mx[REG_W-1:0];
      sqy   <= my[REG_W-1:0] * my[REG_W-1:0];
      sqz   <= mz[REG_W-1:0] * mz[REG_W-1:0];
      rsq3  <= radius * radius;
      side3 <= side2;
      // S4: sum of squares
      sum4  <= (D2_W+2)'(sqx) + (D2_W+2)'(sqy) + (D2_W+2)'(sqz);
      far4  <= far3;
      rsq4  <= rsq3;
      side4 <= side3;
      // S5: exact d <= R on squares
      d2              <= sum4[D2_W-1:0];
      side_out        <= side4;
      side_out.in_sup <= !far4 && (sum4 <= (D2_W+2)'(rsq4));
    end
  end

endmodule

`default_nettype wire

[design/wrd_sqrt.sv]
// ----------------------------------------------------------------------------
// wrd_sqrt: pipelined integer square root
// floor(sqrt(d2 * 2^32)), one root bit per stage, 32 stages.
// ----------------------------------------------------------------------------
`default_nettype none

module wrd_sqrt (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  wire logic [wrd_pkg::D2_W-1:0]    d2,
  input  wire wrd_pkg::side_t              side_in,
  output logic                             out_valid,
  output logic [wrd_pkg::ROOT_W-1:0]       root,
  output wrd_pkg::side_t                   side_out
);
  import wrd_pkg::*;

  logic [REM_W-1:0]  rem_q  [0:ROOT_W];
  logic [ROOT_W-1:0] root_q [0:ROOT_W];
  side_t             side_q [0:ROOT_W];
  logic [ROOT_W:0]   valid_q;

  assign rem_q[0]   = {d2, {(REM_W-D2_W){1'b0}}};
  assign root_q[0]  = '0;
  assign side_q[0]  = side_in;
  assign valid_q[0] = in_valid;

  for (genvar i = 0; i < ROOT_W; i++) begin : g_bit
    localparam int K = ROOT_W - 1 - i;
    logic [REM_W-1:0] trial;
    // (2*root + 2^k) * 2^k
    assign trial = ({{(REM_W-ROOT_W){1'b0}}, root_q[i]} << (K + 1))
                 + ({{(REM_W-1){1'b0}}, 1'b1} << (2 * K));

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[i+1] <= 1'b0;
      end else if (en) begin
        valid_q[i+1] <= valid_q[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_q[i+1] <= side_q[i];
        if (rem_q[i] >= trial) begin
          rem_q[i+1]  <= rem_q[i] - trial;
          root_q[i+1] <= root_q[i] | (ROOT_W'(1) << K);
        end else begin
          rem_q[i+1]  <= rem_q[i];
          root_q[i+1] <= root_q[i];
        end
      end
    end
  end

  assign out_valid = valid_q[ROOT_W];
  assign root      = root_q[ROOT_W];
  assign side_out  = side_q[ROOT_W];

endmodule

`default_nettype wire

[design/wrd_div.sv]
// ----------------------------------------------------------------------------
// wrd_div: pipelined restoring divider
// r = root / R over 17 quotient bits; within support r <= 1.0 in Q0.16.
// ----------------------------------------------------------------------------
`default_nettype none

module wrd_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  wire logic [wrd_pkg::ROOT_W-1:0]  root,
  input  wire logic [wrd_pkg::REG_W-1:0]   radius,
  input  wire wrd_pkg::side_t              side_in,
  output logic                             out_valid,
  output logic [wrd_pkg::Q_W-1:0]          r,
  output wrd_pkg::side_t                   side_out
);
  import wrd_pkg::*;

  logic [DREM_W-1:0] rem_q [0:Q_W];
  logic [Q_W-1:0]    quo_q [0:Q_W];
  side_t             side_q [0:Q_W];
  logic [Q_W:0]      valid_q;

  assign rem_q[0]   = {1'b0, root};
  assign quo_q[0]   = '0;
  assign side_q[0]  = side_in;
  assign valid_q[0] = in_valid;

  for (genvar i = 0; i < Q_W; i++) begin : g_bit
    localparam int K = Q_W - 1 - i;
    logic [DREM_W-1:0] dv;
    assign dv = DREM_W'(radius) << K;

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[i+1] <= 1'b0;
      end else if (en) begin
        valid_q[i+1] <= valid_q[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_q[i+1] <= side_q[i];
        if (rem_q[i] >= dv) begin
          rem_q[i+1] <= rem_q[i] - dv;
          quo_q[i+1] <= quo_q[i] | (Q_W'(1) << K);
        end else begin
          rem_q[i+1] <= rem_q[i];
          quo_q[i+1] <= quo_q[i];
        end
      end
    end
  end

  assign out_valid = valid_q[Q_W];
  assign side_out  = side_q[Q_W];
  // zero radius: only d == 0 is in support, and then r = 0
  assign r = side_q[Q_W].rzero ? '0 : quo_q[Q_W];

endmodule

`default_nettype wire

[design/wrd_weight.sv]
// ----------------------------------------------------------------------------
// wrd_weight: Wendland C2 weight and coefficient scaling
// w = (1-r)^4 (4r+1) in Q0.16, then floor(coeff * w / 2^16); last stage is
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module wrd_weight (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  wire logic [wrd_pkg::Q_W-1:0]     r,
  input  wire wrd_pkg::side_t              side_in,
  output logic                             out_valid,
  output logic [wrd_pkg::REG_W-1:0]        contrib_x,
  output logic [wrd_pkg::REG_W-1:0]        contrib_y,
  output logic [wrd_pkg::REG_W-1:0]        contrib_z,
  output logic                             in_support
);
  import wrd_pkg::*;

  localparam int P_W  = Q_W + 2;        // 1 + 4r, up to 5.0
  localparam int WP_W = Q_W + P_W;
  localparam int CP_W = REG_W + Q_W + 1;

  logic [3:0]          valid;
  side_t               side1, side2, side3, side4;
  logic [Q_W-1:0]      rc, t1, t2, t4, w4;
  logic [P_W-1:0]      p1, p2, p3;
  logic [2*Q_W-1:0]    sq_t, sq_t2;
  logic [WP_W-1:0]     wp;
  logic [WP_W-17:0]    wsh;
  logic signed [CP_W-1:0] px, py, pz;

  assign rc    = (r > ONE_Q16) ? ONE_Q16 : r;
  assign sq_t  = t1 * t1;
  assign sq_t2 = t2 * t2;
  assign wp    = WP_W'(t4) * WP_W'(p3);
  assign wsh   = wp[WP_W-1:16];
  assign px    = side4.coeff_x * $signed({1'b0, w4});
  assign py    = side4.coeff_y * $signed({1'b0, w4});
  assign pz    = side4.coeff_z * $signed({1'b0, w4});

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      valid     <= {valid[2:0], in_valid};
      out_valid <= valid[3];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1    <= ONE_Q16 - rc;
      p1    <= P_W'(ONE_Q16) + {rc, 2'b00};
      side1 <= side_in;
      t2    <= sq_t[Q_W+15:16];
      p2    <= p1;
      side2 <= side1;
      t4    <= sq_t2[Q_W+15:16];
      p3    <= p2;
      side3 <= side2;
      w4    <= (wsh > (WP_W-16)'(ONE_Q16)) ? ONE_Q16 : wsh[Q_W-1:0];
      side4 <= side3;
      // floor toward minus infinity is the arithmetic shift; range fits 16 bits
      contrib_x  <= side4.in_sup ? px[REG_W+15:16] : '0;
      contrib_y  <= side4.in_sup ? py[REG_W+15:16] : '0;
      contrib_z  <= side4.in_sup ? pz[REG_W+15:16] : '0;
      in_support <= side4.in_sup;
    end
  end

endmodule

`default_nettype wire

[design/wendland_rbf_displacement_core.sv]
// ----------------------------------------------------------------------------
// wendland_rbf_displacement_core: Wendland C2 displacement increment
// Scaled distance from voxel to landmark, r = d/R, weight (1-r)^4(4r+1) and
// the three coefficient-times-weight increments with an in-support flag.
// ----------------------------------------------------------------------------
//
//  channel  | handshake          | contents
//  ---------+--------------------+--------------------------------------------
//  s_*      | tvalid/tready      | one request: voxel, center, coefficients
//  m_*      | tvalid/tready      | contrib x/y/z in tdata, in_support in tuser
//  cfg_*    | cfg_we             | spacing x/y/z and support radius, Q8.8 mm
//
//  One request per cycle while no stall on m_tready; 59 register stages: 5
//  distance stages, 32 root stages (one root bit each), 17 divider stages
//  (one quotient bit each), 5 weight stages; a request taken while the
//  pipeline advances goes straight into the first distance stage.
//  Reset (rst, synchronous) clears valid bits and loads spacing 1.0 mm and
//  radius 50.0 mm. A stall on m_tready freezes the whole pipeline; a
//  one-entry skid register keeps s_tready a flop output.
// ----------------------------------------------------------------------------
`default_nettype none

module wendland_rbf_displacement_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  // [9:0] voxel_x, [19:10] voxel_y, [29:20] voxel_z, [39:30] center_x,
  // [49:40] center_y, [59:50] center_z, [75:60] coeff_x, [91:76] coeff_y,
  // [107:92] coeff_z, [111:108] zero
  input  wire logic [wrd_pkg::IN_W-1:0]    s_tdata,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  // [15:0] contrib_x, [31:16] contrib_y, [47:32] contrib_z
  output logic [wrd_pkg::OUT_W-1:0]        m_tdata,
  // [0] in_support
  output logic                             m_tuser,
  input  wire logic                        cfg_we,
  input  wire logic [wrd_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [wrd_pkg::REG_W-1:0]   cfg_data
);
  import wrd_pkg::*;

  logic [REG_W-1:0] spacing_x, spacing_y, spacing_z, radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      spacing_x <= 16'd256;
      spacing_y <= 16'd256;
      spacing_z <= 16'd256;
      radius    <= 16'd12800;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_SPACING_X: spacing_x <= cfg_data;
        REG_SPACING_Y: spacing_y <= cfg_data;
        REG_SPACING_Z: spacing_z <= cfg_data;
        REG_RADIUS:    radius    <= cfg_data;
        default:       ;
      endcase
    end
  end

  // pipeline advances whenever the output register is free or being drained
  logic en;
  assign en = !m_tvalid || m_tready;

  // skid register parks a request taken while the pipeline is frozen
  logic            skid_valid;
  logic [IN_W-1:0] skid_data;
  logic            entry_valid;
  logic [IN_W-1:0] entry_data;

  assign s_tready    = !skid_valid;
  assign entry_valid = skid_valid || s_tvalid;
  assign entry_data  = skid_valid ? skid_data : s_tdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (en) begin
      skid_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && s_tvalid && s_tready) begin
      skid_data <= s_tdata;
    end
  end

  side_t side_in;
  always_comb begin
    side_in         = '0;
    side_in.coeff_x = entry_data[75:60];
    side_in.coeff_y = entry_data[91:76];
    side_in.coeff_z = entry_data[107:92];
  end

  logic              dist_valid, sqrt_valid, div_valid;
  logic [D2_W-1:0]   d2;
  logic [ROOT_W-1:0] root;
  logic [Q_W-1:0]    r;
  side_t             dist_side, sqrt_side, div_side;
  logic [REG_W-1:0]  contrib_x, contrib_y, contrib_z;

  wrd_dist u_dist (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (entry_valid),
    .vx        (entry_data[9:0]),
    .vy        (entry_data[19:10]),
    .vz        (entry_data[29:20]),
    .cx        (entry_data[39:30]),
    .cy        (entry_data[49:40]),
    .cz        (entry_data[59:50]),
    .side_in   (side_in),
    .spacing_x (spacing_x),
    .spacing_y (spacing_y),
    .spacing_z (spacing_z),
    .radius    (radius),
    .out_valid (dist_valid),
    .d2        (d2),
    .side_out  (dist_side)
  );

  wrd_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (dist_valid),
    .d2        (d2),
    .side_in   (dist_side),
    .out_valid (sqrt_valid),
    .root      (root),
    .side_out  (sqrt_side)
  );

  wrd_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sqrt_valid),
    .root      (root),
    .radius    (radius),
    .side_in   (sqrt_side),
    .out_valid (div_valid),
    .r         (r),
    .side_out  (div_side)
  );

  wrd_weight u_weight (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (div_valid),
    .r          (r),
    .side_in    (div_side),
    .out_valid  (m_tvalid),
    .contrib_x  (contrib_x),
    .contrib_y  (contrib_y),
    .contrib_z  (contrib_z),
    .in_support (m_tuser)
  );

  assign m_tdata = {contrib_z, contrib_y, contrib_x};

endmodule

`default_nettype wire
